// ----- rtl/core/cbpc_pkg.sv -----
package cbpc_pkg;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RUN  = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    CAUSE_NONE    = 2'd0,
    CAUSE_BURST   = 2'd1,
    CAUSE_LOW_END = 2'd2,
    CAUSE_TIMEOUT = 2'd3
  } cause_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_RUN_ON_MA     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_RUN_OFF_MA    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_MIN_MA   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MIN_PEAK_MA   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_QUIET_MIN_MS  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BURST_MIN_MS  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_LIMIT_MS = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_COOLDOWN_MS   = 3'd7;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 56;

  typedef struct packed {
    logic [15:0] run_on_ma;
    logic [15:0] run_off_ma;
    logic [15:0] idle_min_ma;
    logic [15:0] min_peak_ma;
    logic [15:0] quiet_min_ms;
    logic [15:0] burst_min_ms;
    logic [31:0] hold_limit_ms;
    logic [31:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [31:0] run_start;
    logic [31:0] low_hold_start;
    logic        low_hold_valid;
    logic [31:0] off_since;
    logic        off_valid;
    logic [15:0] peak_level;
    logic [31:0] last_piece_time;
    logic        last_piece_valid;
    logic [31:0] piece_count;
  } state_t;

  typedef struct packed {
    logic [15:0] peak_ma;
    phase_e      phase_now;
    cause_e      end_cause;
    logic [31:0] piece_total;
    logic        piece_counted;
  } result_t;

endpackage

// ----- rtl/core/cbpc_step.sv -----
module cbpc_step (
  input  cbpc_pkg::cfg_t    cfg_i,
  input  cbpc_pkg::state_t  st_i,
  input  logic [15:0]       amps_ma_i,
  input  logic [31:0]       now_ms_i,
  output cbpc_pkg::state_t  st_o,
  output cbpc_pkg::result_t res_o
);

  cbpc_pkg::state_t st;
  cbpc_pkg::cause_e cause;
  logic             do_end;
  logic             counted;
  logic [15:0]      peak_cur;
  logic [31:0]      off_time;
  logic [31:0]      duration;
  logic [31:0]      since_piece;
  logic [31:0]      hold_time;

  always_comb begin
    st          = st_i;
    cause       = cbpc_pkg::CAUSE_NONE;
    do_end      = 1'b0;
    counted     = 1'b0;
    peak_cur    = st_i.peak_level;
    off_time    = 32'd0;
    hold_time   = now_ms_i - st_i.low_hold_start;
    duration    = now_ms_i - st_i.run_start;
    since_piece = now_ms_i - st_i.last_piece_time;

    case (st_i.phase)
      cbpc_pkg::PH_IDLE: begin
        if (amps_ma_i >= cfg_i.run_on_ma) begin
          st.phase      = cbpc_pkg::PH_RUN;
          st.run_start  = now_ms_i;
          st.peak_level = amps_ma_i;
          st.off_valid  = 1'b0;
        end
      end
      cbpc_pkg::PH_RUN: begin
        if (amps_ma_i > st_i.peak_level) begin
          peak_cur = amps_ma_i;
        end
        st.peak_level = peak_cur;
        if (amps_ma_i < cfg_i.run_off_ma) begin
          // The first low beat starts the off timer at zero elapsed time.
          if (!st_i.off_valid) begin
            st.off_since = now_ms_i;
            st.off_valid = 1'b1;
          end else begin
            off_time = now_ms_i - st_i.off_since;
          end
          if (off_time >= {16'd0, cfg_i.quiet_min_ms}) begin
            if (amps_ma_i < cfg_i.idle_min_ma) begin
              cause  = cbpc_pkg::CAUSE_BURST;
              do_end = 1'b1;
            end else begin
              st.phase          = cbpc_pkg::PH_LOW;
              st.low_hold_start = now_ms_i;
              st.low_hold_valid = 1'b1;
              st.off_valid      = 1'b0;
            end
          end
        end else begin
          st.off_valid = 1'b0;
        end
      end
      cbpc_pkg::PH_LOW: begin
        if (amps_ma_i >= cfg_i.run_on_ma) begin
          st.phase     = cbpc_pkg::PH_RUN;
          st.off_valid = 1'b0;
          if (amps_ma_i > st_i.peak_level) begin
            st.peak_level = amps_ma_i;
          end
        end else begin
          if (amps_ma_i < cfg_i.idle_min_ma) begin
            if (!st_i.off_valid) begin
              st.off_since = now_ms_i;
              st.off_valid = 1'b1;
            end else if ((now_ms_i - st_i.off_since) >= {16'd0, cfg_i.quiet_min_ms}) begin
              cause  = cbpc_pkg::CAUSE_LOW_END;
              do_end = 1'b1;
            end
          end else begin
            st.off_valid = 1'b0;
          end
          // A low-hold end on this beat takes precedence over the timeout.
          if (!do_end && st_i.low_hold_valid && (hold_time > cfg_i.hold_limit_ms)) begin
            cause  = cbpc_pkg::CAUSE_TIMEOUT;
            do_end = 1'b1;
          end
        end
      end
      default: begin
        do_end = 1'b0;
        st.phase          = cbpc_pkg::PH_IDLE;
        st.run_start      = 32'd0;
        st.low_hold_start = 32'd0;
        st.low_hold_valid = 1'b0;
        st.off_since      = 32'd0;
        st.off_valid      = 1'b0;
        st.peak_level     = 16'd0;
      end
    endcase

    if (do_end) begin
      if ((peak_cur >= cfg_i.min_peak_ma) && (duration >= {16'd0, cfg_i.burst_min_ms}) &&
          !(st_i.last_piece_valid && (since_piece < cfg_i.cooldown_ms))) begin
        st.piece_count      = st_i.piece_count + 32'd1;
        st.last_piece_time  = now_ms_i;
        st.last_piece_valid = 1'b1;
        counted             = 1'b1;
      end
      st.phase          = cbpc_pkg::PH_IDLE;
      st.run_start      = 32'd0;
      st.low_hold_start = 32'd0;
      st.low_hold_valid = 1'b0;
      st.off_since      = 32'd0;
      st.off_valid      = 1'b0;
      st.peak_level     = 16'd0;
    end
  end

  assign st_o                = st;
  assign res_o.piece_counted = counted;
  assign res_o.piece_total   = st.piece_count;
  assign res_o.end_cause     = cause;
  assign res_o.phase_now     = st.phase;
  assign res_o.peak_ma       = do_end ? peak_cur : st.peak_level;

endmodule

// ----- rtl/core/current_burst_piece_counter.sv -----
// Counts machining pieces from a stream of current samples. Each input beat carries one
// current sample and a wrapping millisecond timestamp; each produces exactly one output
// beat with the counted flag, running piece total, end cause, phase and burst peak.
// One sample is taken every clock cycle while the output is not stalled; each sample is
// held in one input register, then the combinational phase and threshold logic, and its
// result is held in one result register. Configuration writes must be made while no
// samples are in flight; the thresholds reset to their default values.
module current_burst_piece_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cbpc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [cbpc_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // amps_ma [15:0], now_ms [47:16]
  input  logic [cbpc_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // piece_counted [0], piece_total [32:1], end_cause [34:33], phase_now [36:35],
  // peak_ma [52:37], zero fill [55:53]
  output logic [cbpc_pkg::OutDataW-1:0]     m_axis_tdata
);

  cbpc_pkg::cfg_t    cfg_q;
  cbpc_pkg::state_t  st_q;
  cbpc_pkg::state_t  st_d;
  cbpc_pkg::result_t res_d;
  cbpc_pkg::result_t res_q;

  logic                         in_valid_q;
  logic [cbpc_pkg::InDataW-1:0] in_data_q;
  logic                         out_valid_q;
  logic                         advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_on_ma     <= 16'd500;
      cfg_q.run_off_ma    <= 16'd300;
      cfg_q.idle_min_ma   <= 16'd50;
      cfg_q.min_peak_ma   <= 16'd800;
      cfg_q.quiet_min_ms  <= 16'd150;
      cfg_q.burst_min_ms  <= 16'd300;
      cfg_q.hold_limit_ms <= 32'd5000;
      cfg_q.cooldown_ms   <= 32'd1000;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cbpc_pkg::CFG_RUN_ON_MA:     cfg_q.run_on_ma     <= cfg_data_i[15:0];
        cbpc_pkg::CFG_RUN_OFF_MA:    cfg_q.run_off_ma    <= cfg_data_i[15:0];
        cbpc_pkg::CFG_IDLE_MIN_MA:   cfg_q.idle_min_ma   <= cfg_data_i[15:0];
        cbpc_pkg::CFG_MIN_PEAK_MA:   cfg_q.min_peak_ma   <= cfg_data_i[15:0];
        cbpc_pkg::CFG_QUIET_MIN_MS:  cfg_q.quiet_min_ms  <= cfg_data_i[15:0];
        cbpc_pkg::CFG_BURST_MIN_MS:  cfg_q.burst_min_ms  <= cfg_data_i[15:0];
        cbpc_pkg::CFG_HOLD_LIMIT_MS: cfg_q.hold_limit_ms <= cfg_data_i;
        cbpc_pkg::CFG_COOLDOWN_MS:   cfg_q.cooldown_ms   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  cbpc_step u_step (
    .cfg_i     (cfg_q),
    .st_i      (st_q),
    .amps_ma_i (in_data_q[15:0]),
    .now_ms_i  (in_data_q[47:16]),
    .st_o      (st_d),
    .res_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q             <= 1'b0;
      out_valid_q            <= 1'b0;
      st_q.phase             <= cbpc_pkg::PH_IDLE;
      st_q.run_start         <= 32'd0;
      st_q.low_hold_start    <= 32'd0;
      st_q.low_hold_valid    <= 1'b0;
      st_q.off_since         <= 32'd0;
      st_q.off_valid         <= 1'b0;
      st_q.peak_level        <= 16'd0;
      st_q.last_piece_time   <= 32'd0;
      st_q.last_piece_valid  <= 1'b0;
      st_q.piece_count       <= 32'd0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'd0, res_q};

endmodule
